// File: hw/rtl/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is low
`define FRTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs during reset
`define FRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/frts_pkg.sv
// types and constants of the frame rate tick scheduler
package frts_pkg;

    localparam int unsigned ELAPSED_W  = 16;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned FCOUNT_W   = 16;
    localparam int unsigned ACC_W      = 28;
    localparam int unsigned ACC_SUM_W  = 29;
    localparam int unsigned PERIOD_W   = 28;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [RATE_W-1:0]   RATE_DEFAULT_Q8 = 16'd3072;
    localparam logic [RATE_W-1:0]   RATE_MAX_Q8     = 16'd30720;
    localparam logic [PERIOD_W-1:0] US_PER_SEC_Q8   = 28'd256000000;
    localparam logic [9:0]          US_PER_MS       = 10'd1000;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_MOVIE_LOADED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_RATE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_ADVANCE,
        ST_WRAP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // zero means unspecified, anything above 120.0 is held at 120.0
    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] rate);
        logic [RATE_W-1:0] r;
        r = rate;
        if (r == '0) begin
            r = RATE_DEFAULT_Q8;
        end
        if (r > RATE_MAX_Q8) begin
            r = RATE_MAX_Q8;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/frame_rate_tick_scheduler_core.sv
// frame rate tick scheduler: sequencer, state and stream ports around one divider
//
//  channel    | direction | accepted when                      | payload
//  s_axis     | in        | s_axis_tvalid & s_axis_tready      | elapsed_ms
//  m_axis     | out       | m_axis_tvalid & m_axis_tready      | frame_changed, frame_number
//  cfg        | in        | i_cfg_we                           | register index, value
//
// an active tick runs three divides on the shared divider (period, advance, wrap),
// then loads the output register once it is free and returns to idle to take the
// next request
// an idle tick (not loaded, zero elapsed, count of one or less) skips the divides
// s_axis_tready is high only while the sequencer is idle; a finished result waits in
// the output register and a new request is taken meanwhile
// synchronous active-low reset clears the config registers, state, accumulator, frame and output valid
`include "assert_macros.svh"

module frame_rate_tick_scheduler_core
    import frts_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // tick requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ELAPSED_W-1:0]  s_axis_tdata,   // [15:0] elapsed_ms
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] frame_changed, [16:1] frame_number
);

    localparam int unsigned NW    = (COUNT_BITS < FCOUNT_W) ? COUNT_BITS : FCOUNT_W;
    localparam int unsigned WIDE  = (COUNT_BITS > FCOUNT_W) ? COUNT_BITS : FCOUNT_W;
    localparam int unsigned SUM_W = WIDE + 1;
    localparam int unsigned DW    = (SUM_W > ACC_SUM_W) ? SUM_W : ACC_SUM_W;

    t_state                r_state;
    t_state                n_state;

    logic                  r_loaded;
    logic [FCOUNT_W-1:0]   r_count;
    logic [RATE_W-1:0]     r_rate;

    logic [ACC_W-1:0]      r_accum;
    logic [COUNT_BITS-1:0] r_frame;
    logic [ACC_SUM_W-1:0]  r_acc_sum;
    logic                  r_chg;

    logic                  r_m_valid;
    logic                  r_m_changed;
    logic [FCOUNT_W-1:0]   r_m_frame;

    logic [NW-1:0]         n_frames;
    logic                  active;
    logic [ACC_SUM_W-1:0]  acc_sum;
    logic [SUM_W-1:0]      frame_sum;
    logic [COUNT_BITS-1:0] wrapped;
    logic                  out_free;

    t_div_ctl              div_ctl;
    t_div_stat             div_stat;
    logic [DW-1:0]         div_dividend;
    logic [PERIOD_W-1:0]   div_divisor;
    logic [DW-1:0]         div_quo;
    logic [PERIOD_W-1:0]   div_rem;

    frts_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (PERIOD_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_frames  = r_count[NW-1:0];
        active    = r_loaded && (s_axis_tdata != '0) && (n_frames > NW'(1));
        acc_sum   = ACC_SUM_W'(r_accum)
                  + ACC_SUM_W'(s_axis_tdata) * ACC_SUM_W'(US_PER_MS);
        frame_sum = SUM_W'(r_frame) + SUM_W'(div_quo[FCOUNT_W-1:0]);
        // remainder of the wrap divide is below the frame count
        wrapped   = COUNT_BITS'(div_rem[NW-1:0]);
        out_free  = !r_m_valid || m_axis_tready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = active ? ST_PERIOD : ST_OUT;
                end
            end
            ST_PERIOD: begin
                if (div_stat.done) begin
                    n_state = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                if (div_stat.done) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and divider operands
    always_comb begin
        s_axis_tready = 1'b0;
        div_ctl.start = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                div_ctl.start = s_axis_tvalid && active;
                // period rounded half up
                div_dividend  = DW'(US_PER_SEC_Q8 + PERIOD_W'(clamp_rate(r_rate) >> 1));
                div_divisor   = PERIOD_W'(clamp_rate(r_rate));
            end
            ST_PERIOD: begin
                div_ctl.start = div_stat.done;
                div_dividend  = DW'(r_acc_sum);
                div_divisor   = div_quo[PERIOD_W-1:0];
            end
            ST_ADVANCE: begin
                div_ctl.start = div_stat.done;
                div_dividend  = DW'(frame_sum);
                div_divisor   = PERIOD_W'(n_frames);
            end
            ST_WRAP: begin
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_count  <= '0;
            r_rate   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MOVIE_LOADED: r_loaded <= i_cfg_wdata[0];
                CFG_FRAME_COUNT:  r_count  <= i_cfg_wdata;
                CFG_FRAME_RATE:   r_rate   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // playback state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_frame <= '0;
        end else begin
            if (r_state == ST_ADVANCE && div_stat.done) begin
                r_accum <= div_rem[ACC_W-1:0];
            end
            if (r_state == ST_WRAP && div_stat.done) begin
                r_frame <= wrapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_acc_sum <= acc_sum;
            r_chg     <= 1'b0;
        end else if (r_state == ST_WRAP && div_stat.done) begin
            r_chg     <= (wrapped != r_frame);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_m_changed <= r_chg;
            r_m_frame   <= FCOUNT_W'(r_frame[NW-1:0]);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - FCOUNT_W - 1){1'b0}}, r_m_frame, r_m_changed};

    `FRTS_ASSERT(a_wrap_below_count, i_clk, i_rst_n, (r_state == ST_WRAP && div_stat.done) |=> (r_frame[NW-1:0] < n_frames), "frame not below count after wrap")
    `FRTS_ASSERT(a_accum_held, i_clk, i_rst_n, !(r_state == ST_ADVANCE && div_stat.done) |=> $stable(r_accum), "accumulator changed outside advance step")
    `FRTS_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "new request taken right after accept")
    `FRTS_ASSERT(a_div_idle, i_clk, i_rst_n, (r_state == ST_IDLE || r_state == ST_OUT) |-> !div_stat.busy, "divider busy outside compute states")

endmodule

// File: hw/rtl/frts_div.sv
// shared restoring divider, one quotient bit per cycle
module frts_div
    import frts_pkg::*;
#(
    parameter int unsigned DIVIDEND_W = 29,
    parameter int unsigned DIVISOR_W  = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctl              i_ctl,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output t_div_stat             o_stat,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        ge      = (shifted >= {1'b0, r_dvs});
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so one bit less is enough
            r_rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: tb/frame_rate_tick_scheduler_core_tb.sv
// testbench of the frame rate tick scheduler: stream driver, result monitor and frame predictor
module frame_rate_tick_scheduler_core_tb;
    import frts_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned RANDOM_TICKS = 1830;
    localparam int unsigned CALM_TICKS   = 200;
    localparam int unsigned MAX_PRINTS   = 40;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                changed;
        logic [FCOUNT_W-1:0] frame;
    } t_frame_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ELAPSED_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // predictor copy of the registers and state
    logic                  mdl_loaded = 1'b0;
    logic [FCOUNT_W-1:0]   mdl_count  = '0;
    logic [RATE_W-1:0]     mdl_rate   = '0;
    logic [ACC_W-1:0]      acc_us     = '0;
    logic [FCOUNT_W-1:0]   cur_frame  = '0;

    logic [ELAPSED_W-1:0]  pending_ticks[$];
    t_frame_result         frame_results_q[$];

    logic        idle_on    = 1'b1;
    logic        tick_taken = 1'b0;
    int          send_gap   = 0;
    int          recv_gap   = 0;
    int unsigned ticks_queued  = 0;
    int unsigned ticks_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned frame_changes = 0;
    int unsigned cfg_writes    = 0;
    int unsigned mismatches    = 0;

    frame_rate_tick_scheduler_core #(
        .COUNT_BITS(16)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] frame_period_us(input logic [RATE_W-1:0] rate);
        logic [31:0] r;
        r = 32'(rate);
        if (r == 0) begin
            r = 32'(RATE_DEFAULT_Q8);
        end
        if (r > 32'(RATE_MAX_Q8)) begin
            r = 32'(RATE_MAX_Q8);
        end
        // rounded half up
        return (32'(US_PER_SEC_Q8) + r / 2) / r;
    endfunction

    function automatic t_frame_result tick_frame(input logic [ELAPSED_W-1:0] ms);
        t_frame_result       res;
        logic [31:0]         per;
        logic [31:0]         sum;
        logic [63:0]         steps;
        logic [FCOUNT_W-1:0] prev;
        prev = cur_frame;
        if (mdl_loaded && ms != 0 && mdl_count > 1) begin
            per       = frame_period_us(mdl_rate);
            sum       = 32'(acc_us) + 32'(ms) * 32'(US_PER_MS);
            steps     = 64'(sum / per);
            acc_us    = ACC_W'(sum % per);
            cur_frame = FCOUNT_W'((64'(cur_frame) + steps) % 64'(mdl_count));
        end
        res.changed = (cur_frame != prev);
        res.frame   = cur_frame;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MAX_PRINTS) begin
            $display("mismatch %s at result %0d: got %0h expected %0h",
                     what, results_seen, got, want);
        end
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MOVIE_LOADED: mdl_loaded = val[0];
            CFG_FRAME_COUNT:  mdl_count  = val;
            CFG_FRAME_RATE:   mdl_rate   = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_tick(input logic [ELAPSED_W-1:0] ms);
        pending_ticks.push_back(ms);
        ticks_queued++;
    endtask

    // every request has been taken and answered
    task automatic wait_drained;
        do begin
            @(negedge i_clk);
        end while (ticks_taken != ticks_queued || frame_results_q.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [ELAPSED_W-1:0] pick_elapsed;
        case ($urandom_range(0, 19))
            0:               return '0;
            1:               return '1;
            2, 3, 4, 5, 6:   return ELAPSED_W'($urandom_range(1, 50));
            7, 8, 9, 10, 11: return ELAPSED_W'($urandom_range(51, 2000));
            default:         return ELAPSED_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count;
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'($urandom_range(0, 1));
            1:       return 16'd2;
            2, 3:    return CFG_DATA_W'($urandom_range(2, 12));
            4:       return '1;
            5:       return CFG_DATA_W'($urandom_range(13, 300));
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rate;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(1, 255));
            2:       return RATE_MAX_Q8;
            3:       return CFG_DATA_W'($urandom_range(30721, 65535));
            4:       return '1;
            default: return CFG_DATA_W'($urandom_range(256, 30720));
        endcase
    endfunction

    // request side: a new request or an idle burst whenever the slot is free
    always @(negedge i_clk) begin : tick_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || tick_taken) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                send_gap      <= $urandom_range(0, 18);
                s_axis_tvalid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                s_axis_tdata  <= pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_ready
        if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            recv_gap      <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : stream_monitor
        t_frame_result got;
        t_frame_result want;
        tick_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.changed = m_axis_tdata[0];
            got.frame   = m_axis_tdata[16:1];
            results_seen++;
            if (frame_results_q.size() == 0) begin
                report_mismatch("result with no request pending", got, 0);
            end else begin
                want = frame_results_q.pop_front();
                if (got.changed !== want.changed) begin
                    report_mismatch("frame_changed", got.changed, want.changed);
                end
                if (got.frame !== want.frame) begin
                    report_mismatch("frame_number", got.frame, want.frame);
                end
                if (want.changed) begin
                    frame_changes++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            frame_results_q.push_back(tick_frame(s_axis_tdata));
            ticks_taken++;
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still pending",
                 CYCLE_LIMIT, frame_results_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned      random_ticks;
        int unsigned      burst;
        logic [15:0]      ms;
        bit               wrote;
        random_ticks = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing loaded yet, then loaded with an empty timeline
        queue_tick(16'd100);
        wait_drained;
        write_reg(CFG_MOVIE_LOADED, 16'd1);
        queue_tick(16'd100);
        wait_drained;

        // two frames at the default rate of 12.0: zero elapsed, extremes, period edge
        write_reg(CFG_FRAME_COUNT, 16'd2);
        queue_tick(16'd0);
        queue_tick(16'd1);
        queue_tick(16'hFFFF);
        queue_tick(16'd83);
        queue_tick(16'd84);
        wait_drained;

        // slowest period, accumulator near its top
        write_reg(CFG_FRAME_RATE, 16'd1);
        repeat (4) queue_tick(16'hFFFF);
        wait_drained;

        // rate above 120.0 is clamped, full frame count
        write_reg(CFG_FRAME_RATE, 16'hFFFF);
        write_reg(CFG_FRAME_COUNT, 16'hFFFF);
        queue_tick(16'hFFFF);
        queue_tick(16'd1);
        wait_drained;

        // fill the accumulator slowly, then a fast rate spends many periods at once
        write_reg(CFG_FRAME_RATE, 16'd1);
        repeat (3) queue_tick(16'hFFFF);
        wait_drained;
        write_reg(CFG_FRAME_RATE, RATE_MAX_Q8);
        queue_tick(16'd1);
        wait_drained;

        // frame now beyond the count, brought back by the wrap
        write_reg(CFG_FRAME_COUNT, 16'd3);
        queue_tick(16'd20);
        wait_drained;
        write_reg(CFG_FRAME_COUNT, 16'd1);
        queue_tick(16'd500);
        wait_drained;

        // unknown index is ignored, rate just above the clamp
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_FRAME_COUNT, 16'd10);
        write_reg(CFG_FRAME_RATE, 16'd30721);
        queue_tick(16'd40);
        wait_drained;
        write_reg(CFG_MOVIE_LOADED, 16'hFFFE);
        queue_tick(16'd40);
        wait_drained;

        while (random_ticks < RANDOM_TICKS) begin
            // calm stretches now and then, and none at all near the end
            idle_on = (random_ticks + CALM_TICKS >= RANDOM_TICKS) ? 1'b0
                                                                 : ($urandom_range(0, 3) != 0);
            wrote = 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_MOVIE_LOADED, {15'($urandom_range(0, 32767)),
                                             1'($urandom_range(0, 9) != 0)});
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_FRAME_COUNT, pick_count());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
            end
            if (!wrote || $urandom_range(0, 1) == 1) begin
                write_reg(CFG_FRAME_RATE, pick_rate());
            end
            burst = $urandom_range(10, 60);
            for (int unsigned k = 0; k < burst; k++) begin
                ms = pick_elapsed();
                queue_tick(ms);
                random_ticks++;
            end
            wait_drained;
        end

        idle_on = 1'b0;
        wait_drained;
        repeat (100) @(posedge i_clk);
        if (frame_results_q.size() != 0) begin
            report_mismatch("results never delivered", frame_results_q.size(), 0);
        end
        $display("run: %0d tick requests, %0d results, %0d of them moved the frame",
                 ticks_taken, results_seen, frame_changes);
        $display("config: %0d register writes over rates from 0 to clamp and counts 0 to 65535",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
